FILE: hdl/tswg_pkg.sv
// Package for the square-wave tone generator: field widths, item codes,
// command and divider types shared by the front end, queue, divider and back end.
// No dependencies.
`default_nettype none

package tswg_pkg;

	// Clock of the timer and scaling of the frequency registers
	localparam int unsigned CLOCK_HZ = 3333333;
	localparam int unsigned CENTI    = 100;

	// Tone table
	localparam int unsigned MAX_TONES     = 4;
	localparam int unsigned NUM_TONES_DEF = 4;
	localparam int unsigned CFG_IDX_W     = 2;
	localparam int unsigned FREQ_W        = 24;

	// Input field widths
	localparam int unsigned FUNC_W   = 2;
	localparam int unsigned BUTTON_W = 3;
	localparam int unsigned OCT_W    = 5;

	// Octave-shifted frequency: 24 bits shifted left by up to 15
	localparam int unsigned SHF_W = FREQ_W + 15;

	// Timer
	localparam int unsigned TOP_W = 16;
	localparam logic [TOP_W-1:0] TOP_MAX = {TOP_W{1'b1}};

	// Divider: quotient bits, remainder and shifted divisor widths
	localparam int unsigned Q_W    = TOP_W + 1;
	localparam int unsigned REM_W  = SHF_W + 1;
	localparam int unsigned DSH_W  = SHF_W + Q_W;
	localparam int unsigned STEP_W = $clog2(Q_W);
	localparam logic [REM_W-1:0] DIV_NUM = REM_W'(64'(CLOCK_HZ) * 64'(CENTI));

	// Queue between front and back end
	localparam int unsigned QUEUE_DEPTH = 2;

	// Item kind codes on the input channel
	localparam logic [FUNC_W-1:0] FUNC_PLAY    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_SILENCE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd2;

	// Classified command kinds
	typedef enum logic [1:0] {
		KIND_PLAY    = 2'd0,
		KIND_SILENCE = 2'd1,
		KIND_TICK    = 2'd2,
		KIND_NOP     = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [SHF_W-1:0]   freq;
	} cmd_t;

	typedef struct packed {
		logic               start;
		logic               ack;
		logic [SHF_W-1:0]   freq;
	} div_req_t;

	typedef struct packed {
		logic               ready;
		logic               done;
		logic [TOP_W-1:0]   top;
	} div_rsp_t;

endpackage

`default_nettype wire

FILE: hdl/tswg_if.sv
// Channel interfaces of the tone generator: command items in, result items out.
// Depends on tswg_pkg for the field widths.
`default_nettype none

interface tswg_cmd_if import tswg_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [FUNC_W-1:0]          func;
	logic [BUTTON_W-1:0]        button;
	logic signed [OCT_W-1:0]    octave_offset;

	modport source (output valid, func, button, octave_offset, input ready);
	modport sink   (input valid, func, button, octave_offset, output ready);
endinterface

interface tswg_res_if import tswg_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic                       pin_level;
	logic [TOP_W-1:0]           period_top;
	logic                       tone_active;

	modport source (output valid, pin_level, period_top, tone_active, input ready);
	modport sink   (input valid, pin_level, period_top, tone_active, output ready);
endinterface

`default_nettype wire

FILE: hdl/tswg_front.sv
// Front end: holds the tone frequency registers, accepts command items,
// classifies them and applies the octave shift. Depends on tswg_pkg, tswg_if.
`default_nettype none

module tswg_front import tswg_pkg::*; #(
	parameter int unsigned NUM_TONES = NUM_TONES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [FREQ_W-1:0]    cfg_wdata,
	tswg_cmd_if.sink                  cmd,
	input  wire logic                 full,
	output logic                      push,
	output cmd_t                      push_cmd
);

	localparam int unsigned IDX_W = (NUM_TONES > 1) ? $clog2(NUM_TONES) : 1;

	logic [FREQ_W-1:0]   freq_q [NUM_TONES];
	logic                button_ok;
	logic [IDX_W-1:0]    tone_idx;
	logic [FREQ_W-1:0]   base;
	logic [OCT_W-1:0]    oct;
	logic [OCT_W-1:0]    rshift;

	// Write a tone register; indexes past the table are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TONES; i++) begin
				freq_q[i] <= '0;
			end
		end else if (cfg_we && (32'(cfg_index) < NUM_TONES)) begin
			freq_q[IDX_W'(cfg_index)] <= cfg_wdata;
		end
	end

	// Pick the tone named by the button
	assign button_ok = (cmd.button != '0) && (32'(cmd.button) <= NUM_TONES);
	assign tone_idx  = IDX_W'(cmd.button - BUTTON_W'(1));
	assign base      = button_ok ? freq_q[tone_idx] : '0;

	// Octave shift: negative codes shift right by the magnitude
	assign oct    = cmd.octave_offset;
	assign rshift = OCT_W'(0) - oct;

	// Classify the item and take it while the queue has room
	always_comb begin
		push_cmd.freq = '0;
		if (oct[OCT_W-1]) begin
			push_cmd.freq = SHF_W'(base >> rshift);
		end else begin
			push_cmd.freq = SHF_W'(base) << oct[OCT_W-2:0];
		end
		unique case (cmd.func)
			FUNC_PLAY:    push_cmd.kind = button_ok ? KIND_PLAY : KIND_NOP;
			FUNC_SILENCE: push_cmd.kind = KIND_SILENCE;
			FUNC_TICK:    push_cmd.kind = KIND_TICK;
			default:      push_cmd.kind = KIND_NOP;
		endcase
	end

	assign cmd.ready = !full;
	assign push      = cmd.valid && !full;

endmodule

`default_nettype wire

FILE: hdl/tswg_queue.sv
// Short command queue between the front and back end.
// Depends on tswg_pkg for the command type.
`default_nettype none

module tswg_queue import tswg_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	input  wire logic pop,
	output logic      full,
	output logic      head_valid,
	output cmd_t      head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cmd_t               mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	// Store the pushed command
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: hdl/tswg_div.sv
// Bit-serial divider that turns a shifted frequency into the timer half-period
// top, round(CLOCK_HZ*100 / 2f) - 1 with saturation. Depends on tswg_pkg.
`default_nettype none

module tswg_div import tswg_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CHECK = 4'b0010,
		ST_ITER  = 4'b0100,
		ST_DONE  = 4'b1000
	} div_state_t;

	div_state_t          state_q;
	logic [REM_W-1:0]    rem_q;
	logic [DSH_W-1:0]    dsh_q;
	logic [Q_W-1:0]      quo_q;
	logic [STEP_W-1:0]   step_q;
	logic                sat_q;
	logic                ge;
	logic [Q_W-1:0]      quo_m1;

	// Remainder against the divisor at the current quotient bit
	assign ge = (DSH_W'(rem_q) >= dsh_q);

	// Sequence: load, range check, one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.start) begin
						state_q <= (req.freq == '0) ? ST_DONE : ST_CHECK;
					end
				end
				ST_CHECK: begin
					if ((DSH_W + 1)'(rem_q) >= {dsh_q, 1'b0}) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_ITER;
						step_q  <= STEP_W'(Q_W - 1);
					end
				end
				ST_ITER: begin
					if (step_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				ST_DONE: begin
					if (req.ack) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath: rounding is folded in by adding f to the numerator
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (req.start) begin
					rem_q <= DIV_NUM + REM_W'(req.freq);
					dsh_q <= {req.freq, {Q_W{1'b0}}};
					quo_q <= '0;
					sat_q <= 1'b0;
				end
			end
			ST_CHECK: begin
				if ((DSH_W + 1)'(rem_q) >= {dsh_q, 1'b0}) begin
					sat_q <= 1'b1;
				end
			end
			ST_ITER: begin
				if (ge) begin
					rem_q <= rem_q - dsh_q[REM_W-1:0];
				end
				quo_q <= {quo_q[Q_W-2:0], ge};
				dsh_q <= dsh_q >> 1;
			end
			default: ;
		endcase
	end

	// Drop one from the quotient and clamp to the timer range
	assign quo_m1 = quo_q - Q_W'(1);

	always_comb begin
		if (sat_q || (quo_m1[Q_W-1] && (quo_q != '0))) begin
			rsp.top = TOP_MAX;
		end else if (quo_q == '0) begin
			rsp.top = '0;
		end else begin
			rsp.top = quo_m1[TOP_W-1:0];
		end
	end

	assign rsp.ready = (state_q == ST_IDLE);
	assign rsp.done  = (state_q == ST_DONE);

endmodule

`default_nettype wire

FILE: hdl/tswg_back.sv
// Back end: carries out queued commands on the timer state, drives the
// divider for play commands and holds the result. Depends on tswg_pkg, tswg_if.
`default_nettype none

module tswg_back import tswg_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     head_valid,
	input  wire cmd_t     head,
	output logic          pop,
	output div_req_t      div_req,
	input  wire div_rsp_t div_rsp,
	tswg_res_if.source    res
);

	logic               res_valid_q;
	logic               level_q;
	logic               active_q;
	logic               en_q;
	logic [TOP_W-1:0]   top_q;
	logic [TOP_W-1:0]   count_q;

	logic               level_d;
	logic               active_d;
	logic               en_d;
	logic [TOP_W-1:0]   top_d;
	logic [TOP_W-1:0]   count_d;

	logic               out_free;
	logic               is_play;

	// Result slot is free when empty or being taken this cycle
	assign out_free = !res_valid_q || res.ready;
	assign is_play  = (head.kind == KIND_PLAY);

	// Start the divider on a play at the head; retire once it is done
	assign div_req.freq  = head.freq;
	assign div_req.start = head_valid && is_play && div_rsp.ready;
	assign div_req.ack   = head_valid && is_play && div_rsp.done && out_free;

	assign pop = head_valid && out_free && (!is_play || div_rsp.done);

	// Next timer state for the command at the head
	always_comb begin
		level_d  = level_q;
		active_d = active_q;
		en_d     = en_q;
		top_d    = top_q;
		count_d  = count_q;
		unique case (head.kind)
			KIND_PLAY: begin
				top_d    = div_rsp.top;
				active_d = 1'b1;
				en_d     = 1'b1;
			end
			KIND_SILENCE: begin
				active_d = 1'b0;
				level_d  = 1'b0;
				en_d     = 1'b0;
			end
			KIND_TICK: begin
				if (en_q) begin
					if (count_q == top_q) begin
						count_d = '0;
						level_d = active_q && !level_q;
					end else begin
						count_d = count_q + TOP_W'(1);
					end
				end
			end
			default: ;
		endcase
	end

	// Commit state; the state registers double as the held result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			level_q     <= 1'b0;
			active_q    <= 1'b0;
			en_q        <= 1'b0;
			top_q       <= '0;
			count_q     <= '0;
		end else begin
			if (pop) begin
				res_valid_q <= 1'b1;
				level_q     <= level_d;
				active_q    <= active_d;
				en_q        <= en_d;
				top_q       <= top_d;
				count_q     <= count_d;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid       = res_valid_q;
	assign res.pin_level   = level_q;
	assign res.period_top  = top_q;
	assign res.tone_active = active_q;

	a_silence_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.kind == KIND_SILENCE) |=> (!level_q && !active_q && !en_q))
		else $error("silence did not clear pin, active flag and timer");

	a_idle_pin_low: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> !level_q)
		else $error("pin high while no tone is active");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (head_valid && is_play))
		else $error("divider holds a result with no play at the queue head");

endmodule

`default_nettype wire

FILE: hdl/tone_square_wave_generator.sv
// Top level of the square-wave tone generator.
// Depends on tswg_pkg, tswg_if, tswg_front, tswg_queue, tswg_div, tswg_back.
//
// Tick, silence and ignored items need no divider, so a steady stream of ticks
// is taken at one item per clock with one result per item while results are
// taken. A play item goes through the bit-serial divider that forms the
// half-period top: divider load, range check, 17 quotient steps, commit; when
// the quotient overflows and the top saturates, load, range check and commit;
// when the shifted frequency is zero, load and commit. While a play is
// dividing, the front end keeps taking items into a two-entry queue and then
// holds ready low. Results sit in an output register, so a stalled result
// stalls the back end and the queue fills behind it. Frequency registers are
// written through cfg_we/cfg_index/cfg_wdata and should only change while no
// item is in flight.
`default_nettype none

module tone_square_wave_generator import tswg_pkg::*; #(
	parameter int unsigned NUM_TONES = NUM_TONES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [FREQ_W-1:0]    cfg_wdata,
	tswg_cmd_if.sink                  cmd,
	tswg_res_if.source                res
);

	logic       push;
	cmd_t       push_cmd;
	logic       full;
	logic       pop;
	logic       head_valid;
	cmd_t       head;
	div_req_t   div_req;
	div_rsp_t   div_rsp;

	// Accept and classify
	tswg_front #(
		.NUM_TONES (NUM_TONES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.full      (full),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	// Decouple front and back
	tswg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head       (head)
	);

	// Half-period top for play commands
	tswg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Timer and pin
	tswg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.div_req    (div_req),
		.div_rsp    (div_rsp),
		.res        (res)
	);

endmodule

`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 100ps
// Testbench for the square-wave tone generator: drives play, silence and tick items,
// predicts pin level, compare value and active flag, and checks every result transfer.
// Depends on tswg_pkg, tswg_if and the tone_square_wave_generator RTL.

module tb;
	import tswg_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	localparam int REG_FREQ_ONE   = 0;
	localparam int REG_FREQ_TWO   = 1;
	localparam int REG_FREQ_THREE = 2;
	localparam int REG_FREQ_FOUR  = 3;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 30;

	typedef struct packed {
		logic             pin_level;
		logic [TOP_W-1:0] period_top;
		logic             tone_active;
	} buzzer_state_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [FREQ_W-1:0]    cfg_wdata;

	tswg_cmd_if cmd();
	tswg_res_if res();

	tone_square_wave_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.res       (res)
	);

	// Predicted buzzer state and tone table
	logic [FREQ_W-1:0] tone_freq_m [MAX_TONES];
	logic              pin_m;
	logic              active_m;
	logic              running_m;
	logic [TOP_W-1:0]  top_m;
	logic [TOP_W-1:0]  count_m;
	buzzer_state_t     pin_state_q [$];
	buzzer_state_t     head_state;

	// Traffic shaping
	bit          sender_idles = 1'b0;
	int          burst_left = 0;
	logic [15:0] stall_mask = 16'hFFFF;
	logic [3:0]  stall_step = '0;

	// Statistics
	int cycle_count  = 0;
	int n_plays      = 0;
	int n_silences   = 0;
	int n_ticks      = 0;
	int n_ignored    = 0;
	int n_toggles    = 0;
	int n_results    = 0;
	int n_mismatch   = 0;
	int n_unexpected = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Half-period compare value for a base frequency shifted by a signed octave count
	function automatic logic [TOP_W-1:0] half_period_top(input logic [FREQ_W-1:0] base,
			input logic [OCT_W-1:0] oct);
		logic [63:0] f;
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] q;
		if (oct[OCT_W-1]) begin
			f = 64'(base) >> ((1 << OCT_W) - int'(oct));
		end else begin
			f = 64'(base) << oct;
		end
		if (f == 64'd0)
			return '0;
		num = 64'(CLOCK_HZ) * 64'(CENTI);
		den = 64'd2 * f;
		q = (num + den / 64'd2) / den;
		if (q == 64'd0)
			return '0;
		q = q - 64'd1;
		if (q > 64'(TOP_MAX))
			return TOP_MAX;
		return q[TOP_W-1:0];
	endfunction

	// Advance the predicted state by one accepted item and queue the state it leaves
	task automatic advance_buzzer(input logic [FUNC_W-1:0] func,
			input logic [BUTTON_W-1:0] button, input logic [OCT_W-1:0] oct);
		logic prev_pin;
		prev_pin = pin_m;
		case (func)
			FUNC_PLAY: begin
				if (button != '0 && int'(button) <= NUM_TONES_DEF) begin
					top_m = half_period_top(tone_freq_m[int'(button) - 1], oct);
					active_m = 1'b1;
					running_m = 1'b1;
					n_plays++;
				end else begin
					n_ignored++;
				end
			end
			FUNC_SILENCE: begin
				active_m = 1'b0;
				pin_m = 1'b0;
				running_m = 1'b0;
				n_silences++;
			end
			FUNC_TICK: begin
				if (running_m) begin
					if (count_m == top_m) begin
						count_m = '0;
						pin_m = active_m ? ~pin_m : 1'b0;
					end else begin
						count_m = count_m + TOP_W'(1);
					end
					n_ticks++;
				end else begin
					n_ignored++;
				end
			end
			default: n_ignored++;
		endcase
		if (pin_m != prev_pin)
			n_toggles++;
		pin_state_q.push_back('{pin_m, top_m, active_m});
	endtask

	// Offer one item, hold it until the transfer, then predict its result
	task automatic send_item(input logic [FUNC_W-1:0] func,
			input logic [BUTTON_W-1:0] button, input logic [OCT_W-1:0] oct);
		@(negedge clk);
		if (sender_idles && burst_left == 0) begin
			cmd.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 16);
		end
		cmd.valid         <= 1'b1;
		cmd.func          <= func;
		cmd.button        <= button;
		cmd.octave_offset <= oct;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		advance_buzzer(func, button, oct);
		if (burst_left != 0)
			burst_left--;
	endtask

	task automatic send_tick();
		send_item(FUNC_TICK, BUTTON_W'($urandom), OCT_W'($urandom));
	endtask

	// Drop valid and let every outstanding result drain
	task automatic wait_idle();
		@(negedge clk);
		cmd.valid <= 1'b0;
		while (pin_state_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input int idx, input logic [FREQ_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_IDX_W'(idx);
		cfg_wdata <= data;
		tone_freq_m[idx] = data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Pick a tone, usually one whose top is not below the running counter
	task automatic choose_play(output logic [BUTTON_W-1:0] b, output logic [OCT_W-1:0] o);
		bit need_fit;
		need_fit = ($urandom_range(0, 9) < 8);
		for (int tries = 0; tries < 8; tries++) begin
			b = BUTTON_W'($urandom_range(1, NUM_TONES_DEF));
			if ($urandom_range(0, 4) == 0)
				o = OCT_W'($urandom);
			else
				o = OCT_W'($urandom_range(0, 6) - 3);
			if (!need_fit || half_period_top(tone_freq_m[int'(b) - 1], o) >= count_m)
				break;
		end
	endtask

	// Ignored items and a zero-frequency play with the table at its reset value
	task automatic test_ignored_items();
		send_item(FUNC_TICK, 3'd1, '0);
		send_item(FUNC_PLAY, 3'd0, '0);
		send_item(FUNC_PLAY, 3'd5, OCT_W'(-1));
		send_item(FUNC_PLAY, 3'd6, OCT_W'(5));
		send_item(FUNC_PLAY, 3'd7, OCT_W'(-16));
		send_item(FUNC_UNUSED, 3'd7, OCT_W'(-1));
		// zero frequency gives a zero top, so every tick toggles
		send_item(FUNC_PLAY, 3'd1, '0);
		repeat (3) send_tick();
		send_item(FUNC_SILENCE, 3'd0, '0);
		send_tick();
		wait_idle();
	endtask

	// Saturation, rounding to zero and the widest octave shifts
	task automatic test_frequency_extremes();
		write_reg(REG_FREQ_ONE, 24'd1);
		write_reg(REG_FREQ_TWO, 24'hFFFFFF);
		write_reg(REG_FREQ_THREE, 24'd666667);
		write_reg(REG_FREQ_FOUR, 24'd0);
		send_item(FUNC_PLAY, 3'd1, '0);
		send_item(FUNC_PLAY, 3'd1, OCT_W'(-1));
		send_item(FUNC_PLAY, 3'd2, OCT_W'(15));
		send_item(FUNC_PLAY, 3'd2, OCT_W'(-16));
		send_item(FUNC_PLAY, 3'd2, '0);
		repeat (10) send_tick();
		send_item(FUNC_PLAY, 3'd3, OCT_W'(8));
		send_item(FUNC_PLAY, 3'd3, OCT_W'(-8));
		send_item(FUNC_PLAY, 3'd4, '0);
		repeat (2) send_tick();
		send_item(FUNC_SILENCE, 3'd0, '0);
		send_item(FUNC_PLAY, 3'd3, '0);
		send_tick();
		wait_idle();
	endtask

	// Drop the top below the counter so it runs on past the top without toggling
	task automatic test_counter_overrun();
		write_reg(REG_FREQ_ONE, 24'd833333);
		send_item(FUNC_PLAY, 3'd1, '0);
		while (count_m < 16'd100) send_tick();
		send_item(FUNC_PLAY, 3'd1, OCT_W'(5));
		repeat (48) send_tick();
		send_item(FUNC_SILENCE, 3'd0, '0);
		wait_idle();
	endtask

	task automatic run_random_items(input int n);
		int start;
		logic [BUTTON_W-1:0] b;
		logic [OCT_W-1:0] o;
		start = n_plays + n_silences + n_ticks;
		while (n_plays + n_silences + n_ticks - start < n) begin
			case ($urandom_range(0, 19)) inside
				[0:13]: begin
					// tone followed by a run of ticks, sometimes cut by silence
					choose_play(b, o);
					send_item(FUNC_PLAY, b, o);
					repeat ($urandom_range(1, 48)) send_tick();
					if ($urandom_range(0, 3) == 0) begin
						send_item(FUNC_SILENCE, BUTTON_W'($urandom), OCT_W'($urandom));
						repeat ($urandom_range(0, 3)) send_tick();
					end
				end
				[14:16]: begin
					// noise: unused code, bad buttons, stray ticks
					case ($urandom_range(0, 2))
						0: send_item(FUNC_UNUSED, BUTTON_W'($urandom), OCT_W'($urandom));
						1: begin
							b = BUTTON_W'($urandom_range(0, 3));
							b = (b == '0) ? '0 : b + 3'd4;
							send_item(FUNC_PLAY, b, OCT_W'($urandom));
						end
						default: send_tick();
					endcase
				end
				default: begin
					// broken sequences: back-to-back plays, silence first, play then silence
					case ($urandom_range(0, 2))
						0: begin
							choose_play(b, o);
							send_item(FUNC_PLAY, b, o);
							choose_play(b, o);
							send_item(FUNC_PLAY, b, o);
						end
						1: begin
							send_item(FUNC_SILENCE, BUTTON_W'($urandom), OCT_W'($urandom));
							repeat ($urandom_range(1, 4)) send_tick();
						end
						default: begin
							choose_play(b, o);
							send_item(FUNC_PLAY, b, o);
							send_item(FUNC_SILENCE, BUTTON_W'($urandom), OCT_W'($urandom));
						end
					endcase
				end
			endcase
		end
	endtask

	// Random traffic over several tone tables and idling patterns
	task automatic test_random_traffic();
		for (int phase = 0; phase < 6; phase++) begin
			for (int r = 0; r < MAX_TONES; r++) begin
				case (phase)
					0: write_reg(r, 24'hFFFFFF);
					1: write_reg(r, (r == 0) ? 24'd0 : (r == 1) ? 24'd1 :
							(r == 2) ? 24'hFFFFFF : FREQ_W'($urandom_range(2000000, 16777215)));
					5: write_reg(r, FREQ_W'($urandom));
					default: write_reg(r, FREQ_W'($urandom_range(2000000, 16777215)));
				endcase
			end
			sender_idles = (phase % 3 != 0);
			burst_left = 0;
			stall_mask = (phase % 3 != 1) ? (16'($urandom) | 16'h0101) : 16'hFFFF;
			run_random_items(230);
			wait_idle();
		end
	endtask

	// Receiver stalls follow a repeating 16-bit mask
	always @(negedge clk) begin
		res.ready  <= stall_mask[stall_step];
		stall_step <= stall_step + 4'd1;
	end

	// Compare each result transfer with the oldest prediction
	always @(posedge clk) begin
		if (res.valid && res.ready) begin
			n_results++;
			if (pin_state_q.size() == 0) begin
				n_unexpected++;
				if (n_unexpected <= 10)
					$display("Unexpected result at cycle %0d: pin %0b top %0d active %0b",
						cycle_count, res.pin_level, res.period_top, res.tone_active);
			end else begin
				head_state = pin_state_q.pop_front();
				if (res.pin_level !== head_state.pin_level ||
						res.period_top !== head_state.period_top ||
						res.tone_active !== head_state.tone_active) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display({"Mismatch at cycle %0d: expected pin %0b top %0d active %0b,",
							" got pin %0b top %0d active %0b"}, cycle_count,
							head_state.pin_level, head_state.period_top, head_state.tone_active,
							res.pin_level, res.period_top, res.tone_active);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = '0;
		cfg_wdata         = '0;
		cmd.valid         = 1'b0;
		cmd.func          = FUNC_TICK;
		cmd.button        = '0;
		cmd.octave_offset = '0;
		for (int r = 0; r < MAX_TONES; r++)
			tone_freq_m[r] = '0;
		pin_m     = 1'b0;
		active_m  = 1'b0;
		running_m = 1'b0;
		top_m     = '0;
		count_m   = '0;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		test_ignored_items();
		test_frequency_extremes();
		test_counter_overrun();
		test_random_traffic();

		$display("Sent %0d plays, %0d silences, %0d running ticks and %0d ignored items.",
			n_plays, n_silences, n_ticks, n_ignored);
		$display("Checked %0d results, pin toggled %0d times, %0d mismatches, %0d unexpected.",
			n_results, n_toggles, n_mismatch, n_unexpected);
		if (n_mismatch == 0 && n_unexpected == 0 && pin_state_q.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

FILE: filelist.f
hdl/tswg_pkg.sv
hdl/tswg_if.sv
hdl/tswg_front.sv
hdl/tswg_queue.sv
hdl/tswg_div.sv
hdl/tswg_back.sv
hdl/tone_square_wave_generator.sv
test/tb.sv
